### sv/atc_pkg.sv
`timescale 1ns / 1ps
// atc_pkg: action codes, controller states, command/status structs and the
// CORDIC arctangent table shared by the transform composer. No dependencies.
package atc_pkg;

  localparam int CS_FRAC  = 30;   // CORDIC working fraction bits
  localparam int CS_W     = 34;   // CORDIC x/y/z register width
  localparam int ITER_W   = 5;    // CORDIC iteration index
  localparam int IDX_W    = 3;    // matrix entry index
  localparam int ATAN_LEN = 30;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    ACT_IDENT = 2'd0,
    ACT_TRANS = 2'd1,
    ACT_SCALE = 2'd2,
    ACT_ROT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    B_X,
    B_Y,
    B_C,
    B_S,
    B_NS
  } bsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDENT,
    ST_TRANS,
    ST_ROT,
    ST_CS,
    ST_MAC,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;        // capture input word, init CORDIC
    logic              ident;       // load identity
    logic              trans;       // add offsets
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              cs_load;     // round cos/sin into Q format
    logic              mul;         // issue one multiplier pass
    logic [IDX_W-1:0]  a_idx;
    bsel_t             b_sel;
    logic              hi_part;     // upper slice of a split entry
    logic              first;       // first pass of an entry: clear acc
    logic              last;        // last pass: write result entry
    logic [IDX_W-1:0]  dest;
    logic              commit;      // results -> matrix
    logic              publish;     // matrix -> output register
  } atc_cmd_t;

  typedef struct packed {
    logic mac_pending;
  } atc_stat_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_val(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      5'd24: v = 32'd40;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/atc_datapath.sv
`timescale 1ns / 1ps
// atc_datapath: matrix registers, CORDIC unit, shared multiplier with
// accumulator and saturation, output register. Depends on atc_pkg.
module atc_datapath #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  atc_pkg::atc_cmd_t      cmd,
  output atc_pkg::atc_stat_t     stat,
  input  logic signed [31:0]     x_in,
  input  logic signed [31:0]     y_in,
  input  logic [15:0]            angle_in,
  output logic [5:0][31:0]       out_m,
  output logic                   out_sat
);
  import atc_pkg::*;

  localparam int EW    = ENTRY_WIDTH;
  localparam bit SPLIT = (EW > 32);
  localparam int HALF  = (EW + 1) / 2;
  localparam int MA    = SPLIT ? HALF + 1 : EW;
  localparam int PW    = MA + 32;
  localparam int ACC_W = EW + 33;
  localparam int SUM_W = ((EW > 32) ? EW : 32) + 1;
  localparam bit ONE_SAT = (FRAC_BITS >= EW - 1);
  localparam int D     = CS_FRAC - FRAC_BITS;
  localparam int RND   = (D > 0) ? (1 << (D - 1)) : 0;

  localparam logic [EW-1:0] E_MAX   = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] E_MIN   = {1'b1, {(EW-1){1'b0}}};
  localparam logic [EW-1:0] ONE_VAL = ONE_SAT ? E_MAX : (EW'(1) << FRAC_BITS);
  localparam logic signed [CS_W-1:0] RND_C = CS_W'(RND);

  // {saturated, value}
  function automatic logic [EW:0] clip_acc(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:EW-1] == {(ACC_W-EW+1){v[EW-1]}});
    if (fits) return {1'b0, v[EW-1:0]};
    return {1'b1, (v[ACC_W-1] ? E_MIN : E_MAX)};
  endfunction

  logic signed [EW-1:0]   m   [6];
  logic signed [EW-1:0]   res [6];
  logic signed [31:0]     xv, yv, cv, sv, nsv;
  logic signed [CS_W-1:0] cx, cy, cz;
  logic                   flip;
  logic                   sat;

  logic signed [PW-1:0]   prod;
  logic                   p_valid, p_first, p_last, p_hi;
  logic [IDX_W-1:0]       p_dest;
  logic signed [ACC_W-1:0] acc;

  // input capture / CORDIC start
  logic [31:0]            p_ang;
  logic                   fl_init;
  logic signed [CS_W-1:0] cz_init;

  always_comb begin
    p_ang   = {angle_in, 16'h0000};
    fl_init = (p_ang[31:30] == 2'd1) || (p_ang[31:30] == 2'd2);
    p_ang[31] = p_ang[31] ^ fl_init;
    cz_init = CS_W'($signed(p_ang));
  end

  // CORDIC rotation step
  logic signed [CS_W-1:0] xs, ys, at, cx_n, cy_n, cz_n;
  always_comb begin
    xs = cx >>> cmd.iter;
    ys = cy >>> cmd.iter;
    at = $signed({2'b00, atan_val(cmd.iter)});
    if (!cz[CS_W-1]) begin
      cx_n = cx - ys;
      cy_n = cy + xs;
      cz_n = cz - at;
    end else begin
      cx_n = cx + ys;
      cy_n = cy - xs;
      cz_n = cz + at;
    end
  end

  // round Q2.30 to entry format
  logic signed [CS_W-1:0] c_r, s_r;
  assign c_r = (cx + RND_C) >>> D;
  assign s_r = (cy + RND_C) >>> D;

  // multiplier operands
  logic signed [EW-1:0] a_ent;
  logic signed [MA-1:0] a_op;
  logic signed [31:0]   b_op;

  assign a_ent = m[cmd.a_idx];

  generate
    if (SPLIT) begin : g_split
      always_comb begin
        if (cmd.hi_part) a_op = MA'($signed(a_ent[EW-1:HALF]));
        else             a_op = $signed({1'b0, a_ent[HALF-1:0]});
      end
    end else begin : g_whole
      assign a_op = a_ent;
    end
  endgenerate

  always_comb begin
    unique case (cmd.b_sel)
      B_X:     b_op = xv;
      B_Y:     b_op = yv;
      B_C:     b_op = cv;
      B_S:     b_op = sv;
      B_NS:    b_op = nsv;
      default: b_op = '0;
    endcase
  end

  // accumulate stage
  logic signed [ACC_W-1:0] prod_ext, acc_sum;
  logic [EW:0]             mac_clip;
  always_comb begin
    prod_ext = ACC_W'(prod);
    if (p_hi) prod_ext = prod_ext <<< HALF;
    acc_sum  = (p_first ? '0 : acc) + prod_ext;
    mac_clip = clip_acc(acc_sum >>> FRAC_BITS);
  end

  // translate
  logic signed [SUM_W-1:0] t0_sum, t1_sum;
  logic [EW:0]             t0_clip, t1_clip;
  always_comb begin
    t0_sum  = SUM_W'(m[2]) + SUM_W'(xv);
    t1_sum  = SUM_W'(m[5]) + SUM_W'(yv);
    t0_clip = clip_acc(ACC_W'(t0_sum));
    t1_clip = clip_acc(ACC_W'(t1_sum));
  end

  // matrix state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) m[k] <= (k == 0 || k == 4) ? ONE_VAL : '0;
    end else if (cmd.ident) begin
      for (int k = 0; k < 6; k++) m[k] <= (k == 0 || k == 4) ? ONE_VAL : '0;
    end else if (cmd.trans) begin
      m[2] <= t0_clip[EW-1:0];
      m[5] <= t1_clip[EW-1:0];
    end else if (cmd.commit) begin
      for (int k = 0; k < 6; k++) m[k] <= res[k];
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      sat     <= 1'b0;
    end else begin
      p_valid <= cmd.mul;
      if (cmd.load)
        sat <= 1'b0;
      else if (cmd.ident)
        sat <= ONE_SAT;
      else if (cmd.trans)
        sat <= sat | t0_clip[EW] | t1_clip[EW];
      else if (p_valid && p_last)
        sat <= sat | mac_clip[EW];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xv   <= x_in;
      yv   <= y_in;
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= cz_init;
      flip <= fl_init;
    end else if (cmd.cordic_step) begin
      cx <= cx_n;
      cy <= cy_n;
      cz <= cz_n;
    end
    if (cmd.cs_load) begin
      cv  <= flip ? -32'(c_r) : 32'(c_r);
      sv  <= flip ? -32'(s_r) : 32'(s_r);
      nsv <= flip ? 32'(s_r) : -32'(s_r);
    end
    if (cmd.mul) begin
      prod    <= a_op * b_op;
      p_first <= cmd.first;
      p_last  <= cmd.last;
      p_hi    <= cmd.hi_part;
      p_dest  <= cmd.dest;
    end
    if (p_valid) begin
      acc <= acc_sum;
      if (p_last) res[p_dest] <= mac_clip[EW-1:0];
    end
    if (cmd.publish) begin
      for (int k = 0; k < 6; k++) out_m[k] <= 32'(m[k]);
      out_sat <= sat;
    end
  end

  assign stat.mac_pending = p_valid;

  a_load_no_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !p_valid)
    else $error("new word taken with a multiplier pass in flight");

endmodule

### sv/atc_ctrl.sv
`timescale 1ns / 1ps
// atc_ctrl: sequencer for the transform composer; issues datapath commands
// and owns the input and output handshakes. Depends on atc_pkg.
module atc_ctrl #(
  parameter int ENTRY_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atc_pkg::action_t     in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output atc_pkg::atc_cmd_t    cmd,
  input  atc_pkg::atc_stat_t   stat
);
  import atc_pkg::*;

  localparam bit SPLIT = (ENTRY_WIDTH > 32);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

  state_t            state, state_next;
  action_t           act;
  logic [ITER_W-1:0] iter;
  logic              row, term, half;
  logic [1:0]        col;

  logic half_last, term_last, col_last, mac_done, out_free;
  logic [IDX_W-1:0] dest_idx, rot_idx;

  assign half_last = !SPLIT || half;
  assign term_last = (act != ACT_ROT) || term;
  assign col_last  = (col == 2'd2);
  assign mac_done  = half_last && term_last && col_last && row;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign dest_idx  = IDX_W'(col) + (row ? IDX_W'(3) : IDX_W'(0));
  assign rot_idx   = IDX_W'(col) + (term ? IDX_W'(3) : IDX_W'(0));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_IDENT: state_next = ST_IDENT;
            ACT_TRANS: state_next = ST_TRANS;
            ACT_SCALE: state_next = ST_MAC;
            ACT_ROT:   state_next = ST_ROT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_IDENT:  state_next = ST_DONE;
      ST_TRANS:  state_next = ST_DONE;
      ST_ROT:    if (iter == LAST_ITER) state_next = ST_CS;
      ST_CS:     state_next = ST_MAC;
      ST_MAC:    if (mac_done) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_IDLE) && in_valid;
    cmd.ident       = (state == ST_IDENT);
    cmd.trans       = (state == ST_TRANS);
    cmd.cordic_step = (state == ST_ROT);
    cmd.iter        = iter;
    cmd.cs_load     = (state == ST_CS);
    cmd.mul         = (state == ST_MAC);
    cmd.a_idx       = (act == ACT_ROT) ? rot_idx : dest_idx;
    cmd.hi_part     = half;
    cmd.first       = !half && !term;
    cmd.last        = half_last && term_last;
    cmd.dest        = dest_idx;
    cmd.commit      = (state == ST_COMMIT);
    cmd.publish     = (state == ST_DONE) && out_free;
    if (act == ACT_ROT) begin
      unique case ({row, term})
        2'b00:   cmd.b_sel = B_C;
        2'b01:   cmd.b_sel = B_NS;
        2'b10:   cmd.b_sel = B_S;
        default: cmd.b_sel = B_C;
      endcase
    end else begin
      cmd.b_sel = row ? B_Y : B_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= ACT_IDENT;
      iter <= '0;
      row  <= 1'b0;
      col  <= '0;
      term <= 1'b0;
      half <= 1'b0;
    end else begin
      if (cmd.load) begin
        act  <= in_action;
        iter <= '0;
        row  <= 1'b0;
        col  <= '0;
        term <= 1'b0;
        half <= 1'b0;
      end
      if (state == ST_ROT) iter <= iter + 1'b1;
      if (state == ST_MAC) begin
        if (!half_last) begin
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          if (!term_last) begin
            term <= 1'b1;
          end else begin
            term <= 1'b0;
            if (!col_last) begin
              col <= col + 1'b1;
            end else begin
              col <= '0;
              row <= ~row;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)              out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_ready)   out_valid <= 1'b0;
  end

  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> !stat.mac_pending)
    else $error("commit while a multiplier pass is outstanding");

  a_rot_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == ACT_ROT |=> state == ST_ROT && iter == '0)
    else $error("rotation did not start the CORDIC from step zero");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> out_valid)
    else $error("finished result not moved to the output register");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> cmd.a_idx < 6 && cmd.dest < 6)
    else $error("entry index out of range");

endmodule

### sv/affine_2d_transform_composer_unit.sv
`timescale 1ns / 1ps
// affine_2d_transform_composer_unit: top level of the 2D homogeneous
// transform composer. Depends on atc_pkg, atc_ctrl and atc_datapath.
//
//   channel   dir  word contents
//   s_axis    in   tuser: action; tdata: x_value, y_value, angle
//   m_axis    out  tuser: saturated; tdata: m00 m01 m02 m10 m11 m12
//
// Scale and rotate run each entry product through the single shared multiplier;
//   rotate first steps the serial CORDIC for cos and sin. With ENTRY_WIDTH
//   above 32 every entry product is split into an upper and a lower slice,
//   each a separate pass of that multiplier.
// One word is worked on at a time; s_axis_tready is high only when idle.
// The output register lets the next word be taken while a result waits;
//   a finished word then holds in its last state until the slot frees.
// Reset (rst, synchronous) loads identity and empties the output slot.
module affine_2d_transform_composer_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int ENTRY_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // x_value[31:0], y_value[63:32], angle[79:64]
  input  logic [1:0]   s_axis_tuser,   // action[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // m00, m01, m02, m10, m11, m12, 32 bits each
  output logic [0:0]   m_axis_tuser    // saturated[0]
);
  import atc_pkg::*;

  atc_cmd_t         cmd;
  atc_stat_t        stat;
  action_t          in_action;
  logic [5:0][31:0] out_m;
  logic             out_sat;

  assign in_action = action_t'(s_axis_tuser);

  // sequencer: handshakes and step commands
  atc_ctrl #(
    .ENTRY_WIDTH  (ENTRY_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (in_action),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // matrix, CORDIC, multiply-accumulate and output register
  atc_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .x_in     ($signed(s_axis_tdata[31:0])),
    .y_in     ($signed(s_axis_tdata[63:32])),
    .angle_in (s_axis_tdata[79:64]),
    .out_m    (out_m),
    .out_sat  (out_sat)
  );

  assign m_axis_tdata    = out_m;
  assign m_axis_tuser[0] = out_sat;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: stream of transform actions into the 2D transform composer, each result
// word checked against a typed value or an in-bench Q16.16 CORDIC predictor.
// Depends on atc_pkg and affine_2d_transform_composer_unit.
module testbench;
  import atc_pkg::*;

  localparam int     N_RANDOM  = 1827;
  localparam int     SHOW_MAX  = 10;
  localparam int     TAIL_WAIT = 40;
  localparam int     ROT_STEPS = 16;
  localparam longint GAIN_Q30  = 652032874; // CORDIC gain compensation, Q2.30
  localparam longint ENTRY_MAX = 2147483647;
  localparam longint ENTRY_MIN = -ENTRY_MAX - 1;

  // atan(2^-i) in units of 2^-32 turn, entry i at bits [32*i +: 32]
  localparam logic [ROT_STEPS*32-1:0] ATAN_TURN = {
    32'd20860,    32'd41721,    32'd83443,    32'd166886,
    32'd333772,   32'd667544,   32'd1335087,  32'd2670163,
    32'd5340245,  32'd10679838, 32'd21354465, 32'd42667331,
    32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
  };

  typedef struct packed {
    logic             sat;
    logic [5:0][31:0] m;    // m00 in [0] up to m12 in [5], as on m_axis_tdata
  } mat_word_t;

  typedef struct packed {
    action_t     act;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] ang;
    logic        typed;     // want holds a hand-written result
    mat_word_t   want;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  logic signed [31:0] mat_q [6];            // predicted matrix, m00 m01 m02 m10 m11 m12
  mat_word_t          pending_matrices [$];
  plan_row_t          directed_plan [$];
  int                 bad_words = 0;
  int                 words_seen = 0;
  int                 feed_calm = 0;
  int                 sink_calm = 0;

  affine_2d_transform_composer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mat_word_t mat6(input logic s, input logic [31:0] a0, a1, a2, a3,
                                     a4, a5);
    mat_word_t w;
    w.sat = s;
    w.m   = {a5, a4, a3, a2, a1, a0};
    return w;
  endfunction

  function automatic void load_identity();
    for (int j = 0; j < 6; j++) mat_q[j] = '0;
    mat_q[0] = 32'sh0001_0000;
    mat_q[4] = 32'sh0001_0000;
  endfunction

  function automatic logic signed [31:0] clip_q16(input longint v, inout logic hit);
    if (v > ENTRY_MAX) begin
      hit = 1'b1;
      return 32'(ENTRY_MAX);
    end
    if (v < ENTRY_MIN) begin
      hit = 1'b1;
      return 32'(ENTRY_MIN);
    end
    return 32'(v);
  endfunction

  // cos/sin in Q16.16: fold the left half-plane onto the right, run the
  // iterations in Q2.30, round half up, then undo the fold by negation
  function automatic void cos_sin(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] p;
    logic        flip;
    longint      x, y, z, xs, ys;
    p    = {ang, 16'h0000};
    flip = (p[31:30] == 2'b01) || (p[31:30] == 2'b10);
    if (flip) p[31] = ~p[31];
    z = longint'($signed(p));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN[32*i +: 32]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN[32*i +: 32]);
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  // premultiplies the kept matrix by the action's elementary matrix; identity resets it
  function automatic mat_word_t compose_action(input action_t act,
                                               input logic signed [31:0] xv, yv,
                                               input logic [15:0] ang);
    logic   hit;
    longint c, s, r0, r1;
    hit = 1'b0;
    case (act)
      ACT_IDENT: load_identity();
      ACT_TRANS: begin
        mat_q[2] = clip_q16(longint'(mat_q[2]) + longint'(xv), hit);
        mat_q[5] = clip_q16(longint'(mat_q[5]) + longint'(yv), hit);
      end
      ACT_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          mat_q[j]   = clip_q16((longint'(mat_q[j]) * longint'(xv)) >>> 16, hit);
          mat_q[j+3] = clip_q16((longint'(mat_q[j+3]) * longint'(yv)) >>> 16, hit);
        end
      end
      ACT_ROT: begin
        cos_sin(ang, c, s);
        for (int j = 0; j < 3; j++) begin
          r0 = longint'(mat_q[j]);
          r1 = longint'(mat_q[j+3]);
          mat_q[j]   = clip_q16((c * r0 - s * r1) >>> 16, hit);
          mat_q[j+3] = clip_q16((s * r0 + c * r1) >>> 16, hit);
        end
      end
      default: ;
    endcase
    return mat6(hit, mat_q[0], mat_q[1], mat_q[2], mat_q[3], mat_q[4], mat_q[5]);
  endfunction

  // idle cycles before the next word, with calm stretches of no idling
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic void add_row(input action_t act, input logic [31:0] x, y,
                                  input logic [15:0] ang, input logic typed,
                                  input mat_word_t want);
    plan_row_t r;
    r.act   = act;
    r.x     = x;
    r.y     = y;
    r.ang   = ang;
    r.typed = typed;
    r.want  = want;
    directed_plan.push_back(r);
  endfunction

  // offers one word, waits for it to be taken, then records what should come back
  task automatic issue_action(input action_t act, input logic [31:0] x, y,
                              input logic [15:0] ang, input logic typed,
                              input mat_word_t want);
    int        gap;
    mat_word_t forecast;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, y, x};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    forecast = compose_action(act, x, y, ang);
    pending_matrices.push_back(typed ? want : forecast);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls between words
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    mat_word_t got, want;
    int        diffs;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata};
      words_seen++;
      if (pending_matrices.size() == 0) begin
        bad_words++;
        if (bad_words <= SHOW_MAX)
          $display("result word %0d arrived with nothing expected: sat=%b m=%h",
                   words_seen, got.sat, got.m);
      end else begin
        want  = pending_matrices.pop_front();
        diffs = 0;
        for (int j = 0; j < 6; j++)
          if (got.m[j] !== want.m[j]) diffs++;
        if (got.sat !== want.sat) diffs++;
        if (diffs != 0) begin
          bad_words++;
          if (bad_words <= SHOW_MAX)
            $display("result word %0d, %0d field(s) wrong\n  expected sat=%b m=%h\n  actual   sat=%b m=%h",
                     words_seen, diffs, want.sat, want.m, got.sat, got.m);
        end
      end
    end
  end

  initial begin
    action_t     act;
    logic [31:0] xv, yv, mag;
    logic [15:0] ang;
    int          pick;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_IDENT;
    load_identity();

    // directed: field extremes, clipping, unused fields, quadrant edges of the angle
    add_row(ACT_IDENT, 32'h0, 32'h0, 16'h0, 1'b1,
            mat6(1'b0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0));
    add_row(ACT_TRANS, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1,
            mat6(1'b0, 32'h10000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h10000, 32'h8000_0000));
    add_row(ACT_TRANS, 32'h1, 32'hFFFF_FFFF, 16'h0, 1'b1,
            mat6(1'b1, 32'h10000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h10000, 32'h8000_0000));
    add_row(ACT_IDENT, 32'hDEAD_BEEF, 32'h8123_4567, 16'hA5A5, 1'b1,
            mat6(1'b0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0));
    add_row(ACT_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h5A5A, 1'b1,
            mat6(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0));
    add_row(ACT_SCALE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 1'b1,
            mat6(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0));
    add_row(ACT_SCALE, 32'h0, 32'h0, 16'h0, 1'b1,
            mat6(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    add_row(ACT_TRANS, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 1'b1,
            mat6(1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF));
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h2000, 1'b0, '0);    // clips the x offset
    add_row(ACT_IDENT, 32'h0, 32'h0, 16'h0, 1'b1,
            mat6(1'b0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0));
    add_row(ACT_ROT, 32'hFFFF_FFFF, 32'h0, 16'h0000, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'hFFFF_FFFF, 16'h4000, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h8000, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'hC000, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h3FFF, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h4001, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h7FFF, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'h8001, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'hBFFF, 1'b0, '0);
    add_row(ACT_ROT, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0);
    add_row(ACT_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 1'b0, '0);  // floor on tiny
    add_row(ACT_TRANS, 32'hFFFF_8000, 32'h0001_8000, 16'h1234, 1'b0, '0);
    add_row(ACT_IDENT, 32'h0, 32'h0, 16'h0, 1'b1,
            mat6(1'b0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      issue_action(directed_plan[i].act, directed_plan[i].x, directed_plan[i].y,
                   directed_plan[i].ang, directed_plan[i].typed, directed_plan[i].want);
    wait_drained();

    // random: mostly near-unity scales and modest offsets so the matrix stays
    // in range for long runs, with full-width values mixed in
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 4)       act = ACT_IDENT;
      else if (pick < 34) act = ACT_TRANS;
      else if (pick < 64) act = ACT_SCALE;
      else                act = ACT_ROT;
      ang = 16'($urandom());
      if (act == ACT_SCALE && $urandom_range(0, 7) != 0) begin
        mag = $urandom_range(32'h0000_C000, 32'h0001_4000);
        xv  = $urandom_range(0, 1) ? -mag : mag;
        mag = $urandom_range(32'h0000_C000, 32'h0001_4000);
        yv  = $urandom_range(0, 1) ? -mag : mag;
      end else if (act == ACT_TRANS && $urandom_range(0, 3) != 0) begin
        xv = 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
        yv = 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
      end else begin
        xv = $urandom();
        yv = $urandom();
      end
      issue_action(act, xv, yv, ang, 1'b0, '0);
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_matrices.size() != 0) begin
      bad_words++;
      $display("%0d result word(s) never arrived", pending_matrices.size());
    end
    if (bad_words == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(10_000_000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
